// ===== design/acbs_pkg.sv =====
// ----------------------------------------------------------------------------
// acbs_pkg: shared definitions for the ADC channel block statistics core
// Field widths of the tagged ADC word, the cell clear values and the control
// group that drives each statistics cell.
// ----------------------------------------------------------------------------
package acbs_pkg;

  localparam int WORD_W       = 16;
  localparam int VALUE_W      = 12;
  localparam int CHAN_W       = 3;
  localparam int CHAN_LSB     = 12;
  localparam int NUM_CHANNELS = 8;
  localparam int TOTAL_W      = 32;

  // Minimum starts at the top of the ADC range, maximum at zero
  localparam logic [VALUE_W-1:0] VALUE_TOP = 12'hfff;

  typedef struct packed {
    logic sample;  // fold the broadcast value into this cell
    logic shift;   // load the neighbour's statistics
  } acbs_ctrl_t;

endpackage

// ===== design/acbs_cell.sv =====
// ----------------------------------------------------------------------------
// acbs_cell: one channel's statistics cell
// Holds count, sum, minimum and maximum of one channel; folds in a sample or
// takes over the statistics of the next cell along the chain.
// ----------------------------------------------------------------------------
module acbs_cell #(
  parameter int CNT_W = 11,
  parameter int SUM_W = 22
) (
  input  logic                        clk,
  input  logic                        rst,
  input  acbs_pkg::acbs_ctrl_t        ctrl,
  input  logic [acbs_pkg::VALUE_W-1:0] value,
  input  logic [CNT_W-1:0]            shift_count,
  input  logic [SUM_W-1:0]            shift_sum,
  input  logic [acbs_pkg::VALUE_W-1:0] shift_min,
  input  logic [acbs_pkg::VALUE_W-1:0] shift_max,
  output logic [CNT_W-1:0]            count,
  output logic [SUM_W-1:0]            sum,
  output logic [acbs_pkg::VALUE_W-1:0] vmin,
  output logic [acbs_pkg::VALUE_W-1:0] vmax
);
  import acbs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      vmin  <= VALUE_TOP;
      vmax  <= '0;
    end else if (ctrl.shift) begin
      // advance the chain by one cell
      count <= shift_count;
      sum   <= shift_sum;
      vmin  <= shift_min;
      vmax  <= shift_max;
    end else if (ctrl.sample) begin
      count <= count + CNT_W'(1);
      sum   <= sum + SUM_W'(value);
      if (value < vmin) vmin <= value;
      if (value > vmax) vmax <= value;
    end
  end

endmodule

// ===== design/adc_channel_block_stats_core.sv =====
// ----------------------------------------------------------------------------
// adc_channel_block_stats_core: per-channel block statistics of ADC words
// Gathers count, sum, minimum and maximum for each of eight channels over a
// block of tagged ADC words and reports one result per channel at block end.
// ----------------------------------------------------------------------------
// Sample words are taken at one transaction per clock while no report is
// being sent. A transaction with tlast set closes the block: its own sample
// (if any) is folded in first, then the eight channel results leave on the
// master side, channel 0 first, one per cycle while the sink is ready, with
// tlast on channel 7. During those eight result transactions the slave side
// holds tready low; the chain of channel cells shifts one cell towards the
// output per result taken. A transaction with tuser clear carries no sample
// (used to close an empty block). Samples beyond MAX_BLOCK_SAMPLES in one
// block are dropped. blocks_seen counts closed blocks and wraps; bytes_seen
// adds two bytes per sample at each close and returns to zero instead of
// overflowing.
// ----------------------------------------------------------------------------
module adc_channel_block_stats_core #(
  parameter int MAX_BLOCK_SAMPLES = 1024
) (
  input  logic clk,
  input  logic rst,
  // tdata: sample_word[15:0] (channel in bits 14:12, value in bits 11:0)
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [acbs_pkg::WORD_W-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,   // block_end
  input  logic                          s_axis_tuser,   // sample_present
  // tdata from bit 0 up: sample_count, value_sum, value_min, value_max,
  //   blocks_seen, bytes_seen, zero fill to whole bytes
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [((($clog2(MAX_BLOCK_SAMPLES + 1) + $clog2(MAX_BLOCK_SAMPLES * 4095 + 1)
                  + 88) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                          m_axis_tlast,   // last_result
  output logic [acbs_pkg::CHAN_W-1:0]   m_axis_tuser    // channel
);
  import acbs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int SUM_W  = $clog2(MAX_BLOCK_SAMPLES * 4095 + 1);
  localparam int RAW_W  = CNT_W + SUM_W + 2 * VALUE_W + 2 * TOTAL_W;
  localparam int DATA_W = ((RAW_W + 7) / 8) * 8;

  // Chain taps: index NUM_CHANNELS is the clear value fed into the far end
  logic [CNT_W-1:0]   cnt  [0:NUM_CHANNELS];
  logic [SUM_W-1:0]   sums [0:NUM_CHANNELS];
  logic [VALUE_W-1:0] mins [0:NUM_CHANNELS];
  logic [VALUE_W-1:0] maxs [0:NUM_CHANNELS];

  logic               flushing;
  logic [CHAN_W-1:0]  out_idx;
  logic [CNT_W-1:0]   block_samples;
  logic [TOTAL_W-1:0] blocks_seen;
  logic [TOTAL_W-1:0] bytes_seen;

  logic               s_accept;
  logic               m_accept;
  logic               take;
  logic [CHAN_W-1:0]  sample_chan;
  logic [VALUE_W-1:0] sample_value;
  logic [CNT_W-1:0]   samples_next;
  logic [TOTAL_W:0]   bytes_sum;

  assign s_axis_tready = !flushing;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = flushing;
  assign m_accept      = m_axis_tvalid && m_axis_tready;

  assign sample_chan  = s_axis_tdata[CHAN_LSB +: CHAN_W];
  assign sample_value = s_axis_tdata[VALUE_W-1:0];

  // Drop samples once the block is full
  assign take = s_accept && s_axis_tuser &&
                (block_samples < CNT_W'(MAX_BLOCK_SAMPLES));
  assign samples_next = block_samples + CNT_W'(take);

  // Two bytes per sample; a carry out means the total would overflow
  assign bytes_sum = {1'b0, bytes_seen} + (TOTAL_W + 1)'({samples_next, 1'b0});

  // Clear values enter at the far end of the chain
  assign cnt[NUM_CHANNELS]  = '0;
  assign sums[NUM_CHANNELS] = '0;
  assign mins[NUM_CHANNELS] = VALUE_TOP;
  assign maxs[NUM_CHANNELS] = '0;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    acbs_ctrl_t ctrl;
    assign ctrl.sample = take && (sample_chan == CHAN_W'(i));
    assign ctrl.shift  = m_accept;

    acbs_cell #(
      .CNT_W(CNT_W),
      .SUM_W(SUM_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (sample_value),
      .shift_count(cnt[i+1]),
      .shift_sum  (sums[i+1]),
      .shift_min  (mins[i+1]),
      .shift_max  (maxs[i+1]),
      .count      (cnt[i]),
      .sum        (sums[i]),
      .vmin       (mins[i]),
      .vmax       (maxs[i])
    );
  end

  // Block bookkeeping and flush sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      flushing      <= 1'b0;
      out_idx       <= '0;
      block_samples <= '0;
      blocks_seen   <= '0;
      bytes_seen    <= '0;
    end else begin
      if (s_accept) begin
        if (s_axis_tlast) begin
          block_samples <= '0;
          blocks_seen   <= blocks_seen + TOTAL_W'(1);
          bytes_seen    <= bytes_sum[TOTAL_W] ? '0 : bytes_sum[TOTAL_W-1:0];
          flushing      <= 1'b1;
          out_idx       <= '0;
        end else begin
          block_samples <= samples_next;
        end
      end
      if (m_accept) begin
        out_idx <= out_idx + CHAN_W'(1);
        if (out_idx == CHAN_W'(NUM_CHANNELS - 1)) flushing <= 1'b0;
      end
    end
  end

  // Cell 0 always holds the channel being reported
  assign m_axis_tdata = DATA_W'({bytes_seen, blocks_seen, maxs[0], mins[0], sums[0], cnt[0]});
  assign m_axis_tuser = out_idx;
  assign m_axis_tlast = (out_idx == CHAN_W'(NUM_CHANNELS - 1));

  // A block close starts the report with channel 0
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_axis_tlast |=> m_axis_tvalid && (m_axis_tuser == '0))
    else $error("flush did not start at channel 0");

  // The channel 7 result ends the report
  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    m_accept && m_axis_tlast |=> !m_axis_tvalid)
    else $error("report continued past channel 7");

  // A channel with no samples reports the clear values
  a_empty_channel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (cnt[0] == '0) |->
      (sums[0] == '0) && (mins[0] == VALUE_TOP) && (maxs[0] == '0))
    else $error("empty channel carries statistics");

  // The per-block sample count never passes the block limit
  a_block_limit: assert property (@(posedge clk) disable iff (rst)
    block_samples <= CNT_W'(MAX_BLOCK_SAMPLES))
    else $error("block sample count beyond limit");

  // Two bytes per sample keep the byte total even
  a_bytes_even: assert property (@(posedge clk) disable iff (rst)
    bytes_seen[0] == 1'b0)
    else $error("odd byte total");

endmodule

// ===== tb/tb_adc_channel_block_stats_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_channel_block_stats_core: self-checking bench for the block stats core
// Streams tagged ADC words into the core in blocks. A behavioural copy of the
// per-channel statistics predicts the eight channel results of each block
// close. The checker compares every result transaction field by field against
// the oldest prediction. Both stream sides idle at random, except in the
// closing stretch of the run.
// ----------------------------------------------------------------------------
module tb_adc_channel_block_stats_core;
  import acbs_pkg::*;

  localparam int BLOCK_LIMIT  = 1024;
  localparam int COUNT_W      = $clog2(BLOCK_LIMIT + 1);
  localparam int SUM_W        = $clog2(BLOCK_LIMIT * 4095 + 1);
  localparam int STATS_W      = ((COUNT_W + SUM_W + 88 + 7) / 8) * 8;
  // Bit positions of the result fields in m_axis_tdata
  localparam int SUM_LSB      = COUNT_W;
  localparam int MIN_LSB      = SUM_LSB + SUM_W;
  localparam int MAX_LSB      = MIN_LSB + VALUE_W;
  localparam int BLOCKS_LSB   = MAX_LSB + VALUE_W;
  localparam int BYTES_LSB    = BLOCKS_LSB + TOTAL_W;
  localparam int FILL_LSB     = BYTES_LSB + TOTAL_W;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic [VALUE_W-1:0] vmin;
    logic [VALUE_W-1:0] vmax;
    logic [TOTAL_W-1:0] blocks;
    logic [TOTAL_W-1:0] bytes;
    logic               last;
  } chan_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [WORD_W-1:0]  s_axis_tdata  = '0;   // sample_word
  logic               s_axis_tlast  = 1'b0; // block_end
  logic               s_axis_tuser  = 1'b0; // sample_present
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [STATS_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic [CHAN_W-1:0]  m_axis_tuser;

  // Predicted statistics of the open block
  logic [COUNT_W-1:0] chan_samples [NUM_CHANNELS];
  logic [SUM_W:0]     chan_total   [NUM_CHANNELS];
  logic [VALUE_W-1:0] chan_low     [NUM_CHANNELS];
  logic [VALUE_W-1:0] chan_high    [NUM_CHANNELS];
  logic [COUNT_W-1:0] samples_in_block;
  logic [TOTAL_W-1:0] blocks_closed;
  logic [TOTAL_W-1:0] bytes_total;

  chan_stats_t pending_channel_stats [$];

  int mismatches  = 0;
  int stall_count = 0;
  int sink_hold   = 0;
  bit idle_enable = 1'b1;

  adc_channel_block_stats_core #(
    .MAX_BLOCK_SAMPLES(BLOCK_LIMIT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  task automatic clear_block_stats();
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_samples[c] = '0;
      chan_total[c]   = '0;
      chan_low[c]     = VALUE_TOP;
      chan_high[c]    = '0;
    end
    samples_in_block = '0;
  endtask

  // Fold one accepted transaction into the block; on a close, queue the
  // eight channel results and start a fresh block.
  task automatic update_block_stats(input logic [WORD_W-1:0] word, input logic present,
                                    input logic blk_end);
    logic [CHAN_W-1:0]  ch;
    logic [VALUE_W-1:0] v;
    logic [TOTAL_W-1:0] add;
    chan_stats_t        r;
    ch = word[CHAN_LSB +: CHAN_W];
    v  = word[VALUE_W-1:0];
    // Samples past the block limit are dropped outright
    if (present && samples_in_block < BLOCK_LIMIT) begin
      chan_samples[ch] = chan_samples[ch] + 1'b1;
      chan_total[ch]   = chan_total[ch] + v;
      if (v < chan_low[ch])  chan_low[ch]  = v;
      if (v > chan_high[ch]) chan_high[ch] = v;
      samples_in_block = samples_in_block + 1'b1;
    end
    if (blk_end) begin
      add = TOTAL_W'(samples_in_block) * 2;
      // Byte total falls back to zero rather than overflowing
      if (bytes_total > {TOTAL_W{1'b1}} - add) bytes_total = '0;
      else bytes_total = bytes_total + add;
      blocks_closed = blocks_closed + 1'b1;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        r.chan   = CHAN_W'(c);
        r.count  = chan_samples[c];
        r.sum    = chan_total[c][SUM_W-1:0];
        r.vmin   = chan_low[c];
        r.vmax   = chan_high[c];
        r.blocks = blocks_closed;
        r.bytes  = bytes_total;
        r.last   = (c == NUM_CHANNELS - 1);
        pending_channel_stats.push_back(r);
      end
      clear_block_stats();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Present one transaction and hold it until the core takes it. Called just
  // after a rising edge; tvalid is only dropped when a gap is inserted.
  task automatic send_item(input logic [WORD_W-1:0] word, input logic present,
                           input logic blk_end);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= WORD_W'($urandom);
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= present;
    s_axis_tlast  <= blk_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    update_block_stats(word, present, blk_end);
  endtask

  // Bit 15 carries no meaning, so randomise it
  function automatic logic [WORD_W-1:0] make_word(input logic [CHAN_W-1:0] ch,
                                                  input logic [VALUE_W-1:0] v);
    return {1'($urandom), ch, v};
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return VALUE_TOP;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Range extremes on channels 0 and 7, a sample on every channel, idle
  // transactions, a close carrying a sample, a close without one, and empty blocks.
  task automatic test_directed();
    send_item({1'b0, 3'd0, 12'h000}, 1'b1, 1'b0);
    send_item({1'b0, 3'd0, 12'hfff}, 1'b1, 1'b0);
    send_item({1'b1, 3'd7, 12'h000}, 1'b1, 1'b0);
    send_item({1'b1, 3'd7, 12'hfff}, 1'b1, 1'b0);
    send_item({1'b1, 3'd3, 12'h800}, 1'b1, 1'b0);
    send_item({1'b0, 3'd1, 12'h555}, 1'b1, 1'b0);
    send_item({1'b1, 3'd2, 12'haaa}, 1'b1, 1'b0);
    send_item({1'b0, 3'd4, 12'h001}, 1'b1, 1'b0);
    send_item({1'b0, 3'd6, 12'hffe}, 1'b1, 1'b0);
    // Idle transactions: must change nothing
    send_item(16'hffff, 1'b0, 1'b0);
    send_item(16'h0000, 1'b0, 1'b0);
    // Sample and close together: the sample lands before the flush
    send_item({1'b1, 3'd5, 12'h7ff}, 1'b1, 1'b1);
    // Empty blocks, with garbage on the data lines
    send_item(16'hffff, 1'b0, 1'b1);
    send_item(16'h0000, 1'b0, 1'b1);
    // Close without a sample after real data
    send_item({1'b0, 3'd6, 12'h001}, 1'b1, 1'b0);
    send_item({1'b1, 3'd6, 12'hfff}, 1'b1, 1'b0);
    send_item(16'h7abc, 1'b0, 1'b1);
    // One-transaction block
    send_item({1'b0, 3'd2, 12'hfff}, 1'b1, 1'b1);
  endtask

  // Well-formed blocks of random length and content, some empty, some on a
  // subset of channels, with idle transactions scattered between samples.
  task automatic test_random_blocks(input int target);
    int                sent;
    int                len;
    logic [7:0]        live;
    logic [CHAN_W-1:0] ch;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(17, 60);
        default: len = $urandom_range(1, 16);
      endcase
      live = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'hff;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) send_item(WORD_W'($urandom), 1'b0, 1'b0);
        do ch = CHAN_W'($urandom); while (!live[ch]);
        send_item(make_word(ch, pick_value()), 1'b1, 1'b0);
        sent++;
      end
      do ch = CHAN_W'($urandom); while (!live[ch]);
      if ($urandom_range(0, 4) == 0) send_item(WORD_W'($urandom), 1'b0, 1'b1);
      else send_item(make_word(ch, pick_value()), 1'b1, 1'b1);
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking and sink back-pressure
  // --------------------------------------------------------------------------
  task automatic check_channel_stats();
    chan_stats_t want;
    chan_stats_t got;
    got.chan   = m_axis_tuser;
    got.count  = m_axis_tdata[0 +: COUNT_W];
    got.sum    = m_axis_tdata[SUM_LSB +: SUM_W];
    got.vmin   = m_axis_tdata[MIN_LSB +: VALUE_W];
    got.vmax   = m_axis_tdata[MAX_LSB +: VALUE_W];
    got.blocks = m_axis_tdata[BLOCKS_LSB +: TOTAL_W];
    got.bytes  = m_axis_tdata[BYTES_LSB +: TOTAL_W];
    got.last   = m_axis_tlast;
    if (pending_channel_stats.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected result ch=%0d cnt=%0d sum=%0d min=%0d max=%0d",
                 $realtime, got.chan, got.count, got.sum, got.vmin, got.vmax);
    end else begin
      want = pending_channel_stats.pop_front();
      if (got.chan !== want.chan || got.count !== want.count || got.sum !== want.sum ||
          got.vmin !== want.vmin || got.vmax !== want.vmax || got.blocks !== want.blocks ||
          got.bytes !== want.bytes || got.last !== want.last ||
          (m_axis_tdata >> FILL_LSB) !== '0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display({"%0t: mismatch exp ch=%0d cnt=%0d sum=%0d min=%0d max=%0d",
                    " blk=%0d byt=%0d last=%0b"},
                   $realtime, want.chan, want.count, want.sum, want.vmin, want.vmax,
                   want.blocks, want.bytes, want.last);
          $display({"%0t:          got ch=%0d cnt=%0d sum=%0d min=%0d max=%0d",
                    " blk=%0d byt=%0d last=%0b fill=%h"},
                   $realtime, got.chan, got.count, got.sum, got.vmin, got.vmax,
                   got.blocks, got.bytes, got.last, m_axis_tdata >> FILL_LSB);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_channel_stats();
      // Stall in bursts while idling is on
      if (sink_hold != 0) begin
        sink_hold     <= sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        sink_hold     <= $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("[adc_channel_block_stats_core] ERROR");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_block_stats();
    blocks_closed = '0;
    bytes_total   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_blocks(110);
    // Closing stretch at full rate on both sides
    idle_enable <= 1'b0;
    test_random_blocks(30);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= 1'b0;

    while (pending_channel_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_channel_stats.size() == 0) begin
      $display("[adc_channel_block_stats_core] OK");
    end else begin
      $display("[adc_channel_block_stats_core] ERROR");
    end
    $finish;
  end

endmodule
